### rtl/bfmh_pkg.sv
// Package for the modular-hash Bloom filter: beat types, widths, modes, FSM states.
// No dependencies.
package bfmh_pkg;

    localparam int MAX_TABLE_BITS = 1024;
    localparam int MAX_HASHES     = 4;
    localparam int IDX_W          = $clog2(MAX_TABLE_BITS);
    localparam int HASH_W         = $clog2(MAX_HASHES);
    localparam int CFG_IDX_W      = 3;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MULT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOD        = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] key;
    } in_beat_t;

    typedef struct packed {
        logic       present;
        logic [2:0] bits_found_set;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_DIV1,
        ST_DIV2,
        ST_READ,
        ST_CHECK,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

### rtl/bfmh_divider.sv
// Restoring divider, one quotient bit per cycle; returns the remainder only.
// No dependencies.
module bfmh_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);

    logic [31:0] num_reg, num_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [17:0] diff;

    always_comb begin
        shifted  = {rem_reg[15:0], num_reg[31]};
        diff     = {1'b0, shifted} - {2'b00, div_reg};
        num_next = num_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[30:0], 1'b0};
            rem_next = diff[17] ? shifted : diff[16:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[15:0];

endmodule

### rtl/bloom_filter_modular_hash.sv
// channel | ports                     | beat
// s       | s_valid s_ready s_data    | bfmh_pkg::in_beat_t  (mode, key)
// m       | m_valid m_ready m_data    | bfmh_pkg::out_beat_t (present, bits_found_set)
// cfg     | cfg_valid cfg_ready idx/d | register index, 64-bit data
// Insert/query: per hash a multiply state, then two remainders from the shared divider
// (product mod c, then mod table size), then one read and one check state.
// An insert then writes its bits, one a cycle, after all hashes are checked.
// Clear and reset: a sweep over all 1024 table bits, one bit a cycle; no beat taken then.
// Mode 3 answers present 0 with no bits found. The m register holds the result through stalls;
// the next beat is accepted once it has been taken.
// Depends on bfmh_pkg and bfmh_divider.
module bloom_filter_modular_hash (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bfmh_pkg::in_beat_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bfmh_pkg::out_beat_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    localparam int IW = bfmh_pkg::IDX_W;
    localparam int HW = bfmh_pkg::HASH_W;

    logic [2:0]  num_hashes_reg;
    logic [10:0] table_size_reg;
    logic [63:0] mult_reg, add_reg, mod_reg;

    bfmh_pkg::state_t state_reg, state_next;
    bfmh_pkg::in_beat_t item_reg, item_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [HW:0]   hash_reg, hash_next;
    logic [HW:0]   hcount;
    logic          last_hash;
    logic [10:0]   size_eff;
    logic [31:0]   prod_reg, prod_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] idx_list_reg [bfmh_pkg::MAX_HASHES];
    logic [IW-1:0] idx_list_next [bfmh_pkg::MAX_HASHES];
    logic [2:0]    found_reg, found_next;
    logic          all_reg, all_next;
    logic          mvalid_reg, mvalid_next;
    bfmh_pkg::out_beat_t mdata_reg, mdata_next;

    logic [15:0] a_l, b_l, c_l;
    logic        div_start, div_done;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor, div_rem;

    logic          mem [bfmh_pkg::MAX_TABLE_BITS];
    logic          mem_we, mem_wd, mem_rd_reg;
    logic [IW-1:0] mem_wa;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_hashes_reg <= 3'd1;
            table_size_reg <= 11'd1024;
            mult_reg       <= 64'd1;
            add_reg        <= 64'd0;
            mod_reg        <= 64'h0001_0001_0001_0001;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bfmh_pkg::REG_NUM_HASHES: num_hashes_reg <= cfg_data[2:0];
                bfmh_pkg::REG_TABLE_SIZE: table_size_reg <= cfg_data[10:0];
                bfmh_pkg::REG_MULT:       mult_reg <= cfg_data;
                bfmh_pkg::REG_ADD:        add_reg <= cfg_data;
                bfmh_pkg::REG_MOD:        mod_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign hcount   = (num_hashes_reg > 3'(bfmh_pkg::MAX_HASHES))
                    ? (HW+1)'(bfmh_pkg::MAX_HASHES) : (HW+1)'(num_hashes_reg);
    assign size_eff = (table_size_reg == 11'd0) ? 11'd1
                    : (table_size_reg > 11'(bfmh_pkg::MAX_TABLE_BITS))
                    ? 11'(bfmh_pkg::MAX_TABLE_BITS) : table_size_reg;
    assign last_hash = (hash_reg + 1'b1 == hcount);

    assign a_l = mult_reg[16*hash_reg[HW-1:0] +: 16];
    assign b_l = add_reg[16*hash_reg[HW-1:0] +: 16];
    assign c_l = (mod_reg[16*hash_reg[HW-1:0] +: 16] == 16'd0)
               ? 16'd1 : mod_reg[16*hash_reg[HW-1:0] +: 16];

    bfmh_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_rd_reg <= mem[idx_reg];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfmh_pkg::ST_IDLE:
                if (s_valid && !mvalid_reg) begin
                    if (s_data.mode == bfmh_pkg::MODE_CLEAR)
                        state_next = bfmh_pkg::ST_CLEAR;
                    else if ((s_data.mode == bfmh_pkg::MODE_INSERT
                              || s_data.mode == bfmh_pkg::MODE_QUERY) && hcount != '0)
                        state_next = bfmh_pkg::ST_MUL;
                    else
                        state_next = bfmh_pkg::ST_OUT;
                end
            bfmh_pkg::ST_CLEAR:
                if (sweep_reg == IW'(bfmh_pkg::MAX_TABLE_BITS - 1))
                    state_next = (item_reg.mode == bfmh_pkg::MODE_CLEAR && mvalid_reg == 1'b0
                                  && hash_reg == '0) ? bfmh_pkg::ST_OUT : bfmh_pkg::ST_IDLE;
            bfmh_pkg::ST_MUL:   state_next = bfmh_pkg::ST_DIV1;
            bfmh_pkg::ST_DIV1:  if (div_done) state_next = bfmh_pkg::ST_DIV2;
            bfmh_pkg::ST_DIV2:  if (div_done) state_next = bfmh_pkg::ST_READ;
            bfmh_pkg::ST_READ:  state_next = bfmh_pkg::ST_CHECK;
            bfmh_pkg::ST_CHECK:
                if (!last_hash)
                    state_next = bfmh_pkg::ST_MUL;
                else if (item_reg.mode == bfmh_pkg::MODE_INSERT)
                    state_next = bfmh_pkg::ST_WRITE;
                else
                    state_next = bfmh_pkg::ST_OUT;
            bfmh_pkg::ST_WRITE: if (last_hash) state_next = bfmh_pkg::ST_OUT;
            bfmh_pkg::ST_OUT:   state_next = bfmh_pkg::ST_IDLE;
            default:            state_next = bfmh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        item_next     = item_reg;
        sweep_next    = sweep_reg;
        hash_next     = hash_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        idx_list_next = idx_list_reg;
        found_next    = found_reg;
        all_next      = all_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;
        div_start     = 1'b0;
        div_dividend  = prod_reg;
        div_divisor   = c_l;
        mem_we        = 1'b0;
        mem_wa        = sweep_reg;
        mem_wd        = 1'b0;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        unique case (state_reg)
            bfmh_pkg::ST_IDLE:
                if (s_valid && !mvalid_reg) begin
                    item_next  = s_data;
                    hash_next  = '0;
                    found_next = '0;
                    all_next   = 1'b1;
                    sweep_next = '0;
                end
            bfmh_pkg::ST_CLEAR: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            bfmh_pkg::ST_MUL: begin
                prod_next = {16'd0, a_l} * {16'd0, item_reg.key} + {16'd0, b_l};
                div_start = 1'b1;
                div_dividend = prod_next;
            end
            bfmh_pkg::ST_DIV1:
                if (div_done) begin
                    div_start    = 1'b1;
                    div_dividend = {16'd0, div_rem};
                    div_divisor  = {5'd0, size_eff};
                end
            bfmh_pkg::ST_DIV2:
                if (div_done) idx_next = div_rem[IW-1:0];
            bfmh_pkg::ST_READ: ;
            bfmh_pkg::ST_CHECK: begin
                // bits are set only after every hash has seen the old contents
                if (mem_rd_reg) found_next = found_reg + 3'd1;
                else            all_next = 1'b0;
                idx_list_next[hash_reg[HW-1:0]] = idx_reg;
                hash_next = last_hash ? '0 : hash_reg + 1'b1;
            end
            bfmh_pkg::ST_WRITE: begin
                mem_we    = 1'b1;
                mem_wa    = idx_list_reg[hash_reg[HW-1:0]];
                mem_wd    = 1'b1;
                hash_next = hash_reg + 1'b1;
            end
            bfmh_pkg::ST_OUT: begin
                mvalid_next = 1'b1;
                if (item_reg.mode == bfmh_pkg::MODE_INSERT
                    || item_reg.mode == bfmh_pkg::MODE_QUERY) begin
                    mdata_next.present        = all_reg;
                    mdata_next.bits_found_set = found_reg;
                end else begin
                    mdata_next.present        = 1'b0;
                    mdata_next.bits_found_set = 3'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        idx_list_reg <= idx_list_next;
        found_reg    <= found_next;
        all_reg      <= all_next;
        mdata_reg    <= mdata_next;
        if (!aresetn) begin
            // reset starts a clear sweep with no result due
            state_reg  <= bfmh_pkg::ST_CLEAR;
            sweep_reg  <= '0;
            hash_reg   <= '1;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            hash_reg   <= hash_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == bfmh_pkg::ST_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule

### rtl/bfmh_checker.sv
// Port-level checks for the Bloom filter; bound onto the top level.
// Depends on bfmh_pkg.
module bfmh_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bfmh_pkg::out_beat_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.bits_found_set <= 3'd4)
        else $error("bits_found_set out of range");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken before result");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

endmodule

bind bloom_filter_modular_hash bfmh_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
